// File: rtl/substring_match_position_finder_assert.svh
// assertion macros for the substring match position finder
`ifndef SUBSTRING_MATCH_POSITION_FINDER_ASSERT_SVH
`define SUBSTRING_MATCH_POSITION_FINDER_ASSERT_SVH

`ifndef SYNTH

// condition in the same cycle
`define SMP_ASSERT_SAME(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("smp assertion failed");

// condition in the next cycle
`define SMP_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("smp assertion failed");

`else

`define SMP_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define SMP_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// File: rtl/smp_pkg.sv
package smp_pkg;

	localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;
	localparam int unsigned PAT_BYTES = 16;

	// one subject byte as held in the input register
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic [31:0] pos;
	} smp_item_t;

	// compare result handed to the result register
	typedef struct packed {
		logic        found;
		logic [31:0] start;
	} smp_result_t;

endpackage

// File: rtl/smp_cmp.sv
module smp_cmp
	import smp_pkg::*;
#(
	parameter int MAX_PATTERN = 16
) (
	input  smp_item_t                                   item,
	input  logic [((MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1)-1:0][7:0] window,
	input  logic [63:0]                                 pat_low,
	input  logic [63:0]                                 pat_high,
	input  logic [4:0]                                  pat_len,
	input  logic [31:0]                                 start_pos,
	input  logic [31:0]                                 pos_limit,
	output smp_result_t                                 result
);

	logic [PAT_BYTES-1:0][7:0]   pat;
	logic [MAX_PATTERN-1:0][7:0] hist;
	logic [4:0]                  len_eff;
	logic [4:0]                  diff;
	logic                        eq_all;
	logic                        hit;
	logic [31:0]                 first;
	logic [31:0]                 lo;

	assign pat = {pat_high, pat_low};

	// newest byte first, then the stored history
	always_comb begin
		hist[0] = item.data;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			hist[k] = window[k-1];
		end
	end

	// parallel compare of the history against the pattern, newest byte to its last byte
	always_comb begin
		len_eff = (pat_len > 5'(MAX_PATTERN)) ? 5'(MAX_PATTERN) : pat_len;
		eq_all  = 1'b1;
		diff    = '0;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (5'(k) < len_eff) begin
				diff = len_eff - 5'(k) - 5'd1;
				if (pat[diff[3:0]] != hist[k]) begin
					eq_all = 1'b0;
				end
			end
		end
	end

	// match start and window of reported starts
	always_comb begin
		if (len_eff == 5'd0) begin
			hit   = 1'b1;
			first = item.pos;
		end else begin
			hit   = eq_all && (item.pos >= 32'(len_eff));
			first = item.pos - 32'(len_eff) + 32'd1;
		end
		lo           = (start_pos == 32'd0) ? 32'd1 : start_pos;
		result.found = hit && (first >= lo) && (first <= pos_limit);
		result.start = result.found ? first : 32'd0;
	end

endmodule

// File: rtl/substring_match_position_finder.sv
// Streaming substring search: one subject byte is taken per clock while in_stall is low, and
// one result word per byte comes back via the input register, then the result register;
// both channels sustain one word per cycle while out_stall is low (combinational compare).
// A result flags a match of the configured pattern (up to MAX_PATTERN bytes, longer lengths
// act as MAX_PATTERN) that ends at this byte and gives its 1-based start, 0 if none; matches
// may overlap, and starts outside start_position..position_limit are dropped. A zero length
// matches at every byte. The byte counter saturates at all ones, and both history and counter
// clear after a word with last_byte set. Write the registers only while the block is idle.
`include "substring_match_position_finder_assert.svh"

module substring_match_position_finder
	import smp_pkg::*;
#(
	parameter int MAX_PATTERN = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// subject bytes
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  subject_byte,
	input  logic        last_byte,
	// results
	output logic        out_valid,
	input  logic        out_stall,
	output logic        match_found,
	output logic [31:0] match_start,
	output logic        subject_done
);

	localparam int WIN_D = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

	localparam logic [2:0] CFG_PAT_LOW   = 3'd0;
	localparam logic [2:0] CFG_PAT_HIGH  = 3'd1;
	localparam logic [2:0] CFG_PAT_LEN   = 3'd2;
	localparam logic [2:0] CFG_START_POS = 3'd3;
	localparam logic [2:0] CFG_POS_LIMIT = 3'd4;

	logic [63:0] pat_low_q;
	logic [63:0] pat_high_q;
	logic [4:0]  pat_len_q;
	logic [31:0] start_pos_q;
	logic [31:0] pos_limit_q;

	logic [WIN_D-1:0][7:0] window_q;
	logic [31:0]           pos_q;
	logic [31:0]           pos_next;

	logic                  valid_s1;
	smp_item_t             item_s1;
	logic [WIN_D-1:0][7:0] window_s1;

	logic        out_valid_q;
	logic        found_q;
	logic [31:0] start_q;
	logic        done_q;

	logic        accept;
	logic        advance;
	smp_result_t result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q   <= '0;
			pat_high_q  <= '0;
			pat_len_q   <= '0;
			start_pos_q <= 32'd1;
			pos_limit_q <= POS_MAX;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_PAT_LOW:   pat_low_q   <= cfg_data;
				CFG_PAT_HIGH:  pat_high_q  <= cfg_data;
				CFG_PAT_LEN:   pat_len_q   <= cfg_data[4:0];
				CFG_START_POS: start_pos_q <= cfg_data[31:0];
				CFG_POS_LIMIT: pos_limit_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// handshake: the result register frees the input register
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// saturating byte position
	assign pos_next = (pos_q == POS_MAX) ? POS_MAX : pos_q + 32'd1;

	// byte history and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			pos_q    <= '0;
		end else if (accept) begin
			if (last_byte) begin
				window_q <= '0;
				pos_q    <= '0;
			end else begin
				for (int j = WIN_D - 1; j > 0; j--) begin
					window_q[j] <= window_q[j-1];
				end
				window_q[0] <= subject_byte;
				pos_q       <= pos_next;
			end
		end
	end

	// input register, loads whenever it is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.data <= subject_byte;
			item_s1.last <= last_byte;
			item_s1.pos  <= pos_next;
			window_s1    <= window_q;
		end
	end

	smp_cmp #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_cmp (
		.item      (item_s1),
		.window    (window_s1),
		.pat_low   (pat_low_q),
		.pat_high  (pat_high_q),
		.pat_len   (pat_len_q),
		.start_pos (start_pos_q),
		.pos_limit (pos_limit_q),
		.result    (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			found_q <= result.found;
			start_q <= result.start;
			done_q  <= item_s1.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign match_found  = found_q;
	assign match_start  = start_q;
	assign subject_done = done_q;

	// checks
	`SMP_ASSERT_SAME(a_found_has_start, clk, arst_n, out_valid_q && found_q, start_q != 32'd0)
	`SMP_ASSERT_SAME(a_miss_zero_start, clk, arst_n, out_valid_q && !found_q, start_q == 32'd0)
	`SMP_ASSERT_NEXT(a_last_clears_pos, clk, arst_n, accept && last_byte, pos_q == 32'd0)
	`SMP_ASSERT_NEXT(a_pos_advances, clk, arst_n, accept && !last_byte, pos_q != 32'd0)
	`SMP_ASSERT_SAME(a_stall_needs_full, clk, arst_n, in_stall, valid_s1 && out_valid_q)

endmodule
